/* rtl/complex_chirp_generator_core_macros.svh */
// Assertion macros shared by the chirp generator RTL.
// Expects clk and rst in the scope of the module that uses them.
`ifndef COMPLEX_CHIRP_GENERATOR_CORE_MACROS_SVH
`define COMPLEX_CHIRP_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define CCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ccg_pkg.sv */
// Package for the complex chirp generator: field widths, register codes,
// elaboration-time sine/cosine table math and the output packing helper.
// No dependencies.
`default_nettype none

package ccg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 24;
  localparam int PHASE_W  = 48;
  localparam int COUNT_W  = 24;
  localparam int MAG_W    = 17;

  typedef enum logic [1:0] {
    CFG_TONE_STEP    = 2'd0,
    CFG_CHIRP_COEF   = 2'd1,
    CFG_SAMPLE_COUNT = 2'd2
  } cfg_reg_t;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;
  localparam logic [63:0] ROUND_Q15   = 64'h0000400000000000;

  // Taylor divisors (2n)(2n+1) for sine, (2n-1)(2n) for cosine, as
  // ceil(2^74 / d); exact floor division for any 64-bit dividend
  localparam int          RECIP_SH  = 74;
  localparam logic [74:0] RECIP_ONE = 75'd1 << RECIP_SH;

  localparam logic [74:0] SIN_RECIP [14] = '{
    (RECIP_ONE + 75'd5) / 75'd6,     (RECIP_ONE + 75'd19) / 75'd20,
    (RECIP_ONE + 75'd41) / 75'd42,   (RECIP_ONE + 75'd71) / 75'd72,
    (RECIP_ONE + 75'd109) / 75'd110, (RECIP_ONE + 75'd155) / 75'd156,
    (RECIP_ONE + 75'd209) / 75'd210, (RECIP_ONE + 75'd271) / 75'd272,
    (RECIP_ONE + 75'd341) / 75'd342, (RECIP_ONE + 75'd419) / 75'd420,
    (RECIP_ONE + 75'd505) / 75'd506, (RECIP_ONE + 75'd599) / 75'd600,
    (RECIP_ONE + 75'd701) / 75'd702, (RECIP_ONE + 75'd811) / 75'd812};
  localparam logic [74:0] COS_RECIP [14] = '{
    (RECIP_ONE + 75'd1) / 75'd2,     (RECIP_ONE + 75'd11) / 75'd12,
    (RECIP_ONE + 75'd29) / 75'd30,   (RECIP_ONE + 75'd55) / 75'd56,
    (RECIP_ONE + 75'd89) / 75'd90,   (RECIP_ONE + 75'd131) / 75'd132,
    (RECIP_ONE + 75'd181) / 75'd182, (RECIP_ONE + 75'd239) / 75'd240,
    (RECIP_ONE + 75'd305) / 75'd306, (RECIP_ONE + 75'd379) / 75'd380,
    (RECIP_ONE + 75'd461) / 75'd462, (RECIP_ONE + 75'd551) / 75'd552,
    (RECIP_ONE + 75'd649) / 75'd650, (RECIP_ONE + 75'd755) / 75'd756};

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] mul_recip(input logic [63:0] t, input logic [74:0] m);
    logic [138:0] p;
    p = {75'd0, t} * {64'd0, m};
    return p[137:74];
  endfunction

  function automatic logic [63:0] series_q62(input logic [63:0] x, input logic want_sin);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q62(x, x);
    term = want_sin ? x : ONE_Q62;
    sum  = term;
    for (int n = 1; n <= 14; n++) begin
      if (want_sin) begin
        term = mul_recip(mul_q62(term, x2), SIN_RECIP[n-1]);
      end else begin
        term = mul_recip(mul_q62(term, x2), COS_RECIP[n-1]);
      end
      if ((n & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [MAG_W-1:0] to_q15(input logic [63:0] v);
    logic [63:0] r;
    r = v + ROUND_Q15;
    return r[47+MAG_W-1:47];
  endfunction

  // {sin, cos} magnitudes of angle m quarter-turn/2^(tb-2)
  function automatic logic [2*MAG_W-1:0] sincos_entry(input int unsigned m,
                                                      input int unsigned tb);
    logic [63:0] step;
    logic [63:0] a;
    step = HALF_PI_Q62 >> (tb - 2);
    a    = step * 64'(m);
    return {to_q15(series_q62(a, 1'b1)), to_q15(series_q62(a, 1'b0))};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pack16(input logic [MAG_W-1:0] mag,
                                                        input logic neg);
    logic [MAG_W-1:0] n;
    if (neg) begin
      n = -mag;
      return n[SAMPLE_W-1:0];
    end else if (mag > MAG_W'(32767)) begin
      return SAMPLE_W'(32767);
    end else begin
      return mag[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/ccg_sincos_rom.sv */
// Synchronous sine/cosine ROM covering the first eighth of a turn.
// Contents built at elaboration from ccg_pkg::sincos_entry.
`default_nettype none

module ccg_sincos_rom #(
  parameter int TABLE_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [TABLE_BITS-3:0]          addr,
  output      logic [2*ccg_pkg::MAG_W-1:0]    data
);
  import ccg_pkg::*;

  localparam int DEPTH = (1 << (TABLE_BITS - 3)) + 1;

  logic [2*MAG_W-1:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom[g] = sincos_entry(g, TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/complex_chirp_generator_core.sv */
// Complex chirp generator top level: config registers, phase/frequency
// accumulators, sine ROM pipeline and output register.
// Depends on ccg_pkg, ccg_sincos_rom and the assertion macro header.
//
// Usage:
//  - s_axis: one word per sample request; tdata[0] = restart, which starts
//    the pulse over at sample zero before producing the sample.
//  - m_axis: one word per request: tdata = {sample_index, imag, real},
//    tlast flags the final sample of the pulse; the pulse then repeats.
//  - cfg_*: write tone_step (0), chirp_coef (1), sample_count (2) while
//    idle; tone_step applies at the next restart or pulse end, while
//    chirp_coef and sample_count apply at once.
//  - An accepted word passes the ROM read stage, then the output register.
//    Throughput is one word per clock unless m_axis stalls; the accumulators
//    update in the accept cycle and the registered ROM read forms the middle stage.
//  - Reset clears the accumulators, the registers (sample_count = 1) and
//    the pipeline. When m_axis stalls the pipeline holds its words and
//    s_axis_tready drops once both stages are full.
`default_nettype none

`include "complex_chirp_generator_core_macros.svh"

module complex_chirp_generator_core #(
  parameter int TABLE_BITS = 12,
  parameter int INDEX_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] restart
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [55:0] m_axis_tdata,   // [15:0] real, [31:16] imag, [55:32] index
  output      logic        m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  import ccg_pkg::*;

  localparam int QW = TABLE_BITS - 2;
  localparam int CW = (INDEX_BITS > COUNT_W) ? INDEX_BITS : COUNT_W;

  // configuration
  logic [PHASE_W-1:0] tone_step;
  logic [PHASE_W-1:0] chirp_coef;
  logic [PHASE_W-1:0] reload_freq;
  logic [COUNT_W-1:0] final_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_step   <= '0;
      chirp_coef  <= '0;
      reload_freq <= '0;
      final_pos   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TONE_STEP: begin
          tone_step   <= cfg_data;
          reload_freq <= cfg_data + chirp_coef;
        end
        CFG_CHIRP_COEF: begin
          chirp_coef  <= cfg_data;
          reload_freq <= tone_step + cfg_data;
        end
        CFG_SAMPLE_COUNT: begin
          final_pos <= (cfg_data[COUNT_W-1:0] == '0) ? '0
                                                     : cfg_data[COUNT_W-1:0] - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // accumulators
  logic [INDEX_BITS-1:0] position;
  logic [PHASE_W-1:0]    phase_acc;
  logic [PHASE_W-1:0]    freq_acc;

  logic                  in_acc;
  logic                  restart;
  logic [INDEX_BITS-1:0] eff_pos;
  logic [PHASE_W-1:0]    eff_phase;
  logic [PHASE_W-1:0]    eff_freq;
  logic [INDEX_BITS-1:0] pos_inc;
  logic                  is_last;
  logic [CW-1:0]         pos_ext;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign restart   = s_axis_tdata[0];
  assign eff_pos   = restart ? '0 : position;
  assign eff_phase = restart ? '0 : phase_acc;
  assign eff_freq  = restart ? reload_freq : freq_acc;
  assign pos_inc   = eff_pos + 1'b1;
  assign pos_ext   = CW'(eff_pos);
  assign is_last   = (pos_ext == CW'(final_pos)) || (&eff_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      phase_acc <= '0;
      freq_acc  <= '0;
    end else if (in_acc) begin
      if (is_last) begin
        position  <= '0;
        phase_acc <= '0;
        freq_acc  <= reload_freq;
      end else begin
        position  <= pos_inc;
        phase_acc <= eff_phase + eff_freq;
        freq_acc  <= eff_freq + {chirp_coef[PHASE_W-2:0], 1'b0};
      end
    end
  end

  // table address: quadrant, mirror within the quadrant
  logic [1:0]      quad;
  logic [QW-1:0]   r;
  logic            mirror;
  logic [QW:0]     r_comp;
  logic [QW-2+1:0] rom_addr_full;
  logic [QW-1:0]   rom_addr;

  assign quad          = eff_phase[PHASE_W-1 -: 2];
  assign r             = eff_phase[PHASE_W-3 -: QW];
  assign mirror        = r > {1'b1, {(QW-1){1'b0}}};
  assign r_comp        = {1'b1, {QW{1'b0}}} - {1'b0, r};
  assign rom_addr_full = mirror ? r_comp[QW-1:0] : r;
  assign rom_addr      = rom_addr_full;

  // pipeline control
  logic en1;
  logic en2;
  logic v1;

  assign en2           = !m_axis_tvalid || m_axis_tready;
  assign en1           = !v1 || en2;
  assign s_axis_tready = en1;

  // stage 1: ROM read
  logic [2*MAG_W-1:0]  rom_q;
  logic [1:0]          s1_quad;
  logic                s1_mirror;
  logic [INDEX_W-1:0]  s1_index;
  logic                s1_last;

  ccg_sincos_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_rom (
    .clk (clk),
    .en  (in_acc),
    .addr(rom_addr[TABLE_BITS-3:0]),
    .data(rom_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_quad   <= quad;
      s1_mirror <= mirror;
      s1_index  <= pos_ext[INDEX_W-1:0];
      s1_last   <= is_last;
    end
  end

  // stage 2: quadrant fold and output register
  logic [MAG_W-1:0]           s_mag;
  logic [MAG_W-1:0]           c_mag;
  logic signed [SAMPLE_W-1:0] re_next;
  logic signed [SAMPLE_W-1:0] im_next;
  logic signed [SAMPLE_W-1:0] out_re;
  logic signed [SAMPLE_W-1:0] out_im;
  logic [INDEX_W-1:0]         out_index;

  assign s_mag = s1_mirror ? rom_q[MAG_W-1:0] : rom_q[2*MAG_W-1:MAG_W];
  assign c_mag = s1_mirror ? rom_q[2*MAG_W-1:MAG_W] : rom_q[MAG_W-1:0];

  always_comb begin
    case (s1_quad)
      2'd0: begin
        re_next = pack16(c_mag, 1'b0);
        im_next = pack16(s_mag, 1'b0);
      end
      2'd1: begin
        re_next = pack16(s_mag, 1'b1);
        im_next = pack16(c_mag, 1'b0);
      end
      2'd2: begin
        re_next = pack16(c_mag, 1'b1);
        im_next = pack16(s_mag, 1'b1);
      end
      default: begin
        re_next = pack16(s_mag, 1'b0);
        im_next = pack16(c_mag, 1'b1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en2) begin
      m_axis_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      out_re       <= re_next;
      out_im       <= im_next;
      out_index    <= s1_index;
      m_axis_tlast <= s1_last;
    end
  end

  assign m_axis_tdata = {out_index, out_im, out_re};

  `CCG_ASSERT_NEXT(a_last_restarts, in_acc && is_last, position == '0 && phase_acc == '0, "pulse did not restart after last word")
  `CCG_ASSERT_NEXT(a_pos_advance, in_acc && !is_last, position == $past(pos_inc), "position did not advance")
  `CCG_ASSERT_NEXT(a_s1_hold, v1 && !en2, v1 && $stable(rom_q) && $stable(s1_index), "stage 1 lost its word under stall")
  `CCG_ASSERT_NOW(a_out_from_s1, $rose(m_axis_tvalid), $past(v1), "output word without stage 1 data")

endmodule

`default_nettype wire

/* sim/complex_chirp_generator_core_test.sv */
// Testbench for complex_chirp_generator_core: drives sample requests and config
// writes, predicts every tone/chirp sample and checks the output stream.
// Depends on ccg_pkg and the RTL of complex_chirp_generator_core.
`timescale 1ns / 1ps

module complex_chirp_generator_core_test;
  import ccg_pkg::*;

  localparam logic [1:0]  CFG_SPARE_INDEX = 2'd3;  // unmapped, writes are ignored
  localparam logic [63:0] PI_HALF_Q62     = 64'h6487ED5110B4611A;
  localparam logic [63:0] UNITY_Q62       = 64'h4000000000000000;
  localparam logic [63:0] HALF_LSB_Q15    = 64'h0000400000000000;
  localparam logic [47:0] PHASE_ALL_ONES  = 48'hFFFFFFFFFFFF;
  localparam logic [47:0] CHIRP_MOST_NEG  = 48'h800000000000;
  localparam logic [47:0] CHIRP_MOST_POS  = 48'h7FFFFFFFFFFF;
  localparam logic [23:0] COUNT_MAX       = 24'hFFFFFF;

  typedef struct packed {
    logic signed [15:0] re_part;
    logic signed [15:0] im_part;
    logic [23:0]        sample_index;
    logic               last_flag;
  } sample_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;  // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;         // [15:0] real, [31:16] imag, [55:32] index
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [47:0] cfg_data = 48'd0;

  complex_chirp_generator_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("complex_chirp_generator_core: mismatch");
    $finish;
  end

  // generator shadow state
  logic [47:0] cfg_tone_step;
  logic [47:0] cfg_chirp_coef;
  logic [23:0] cfg_sample_count;
  logic [23:0] gen_position;
  logic [47:0] gen_phase;
  logic [47:0] gen_freq;
  int          sin_quarter [0:512];
  int          cos_quarter [0:512];

  sample_t     expected_samples [$];
  int          error_count = 0;
  int          gap_max = 0;
  int          burst_left = 0;
  int          hold_off_cycles = 0;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  function automatic logic [63:0] taylor_q62(input logic [63:0] x, input bit odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] div;
    x2   = q62_mul(x, x);
    term = odd ? x : UNITY_Q62;
    sum  = term;
    for (int n = 1; n <= 14; n++) begin
      div  = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = q62_mul(term, x2) / div;
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic int q62_to_q15_mag(input logic [63:0] v);
    logic [63:0] t;
    t = (v + HALF_LSB_Q15) >> 47;
    return int'(t);
  endfunction

  function automatic logic [15:0] signed_q15(input int mag, input bit neg);
    int s;
    s = neg ? -mag : mag;
    if (s > 32767) s = 32767;
    return s[15:0];
  endfunction

  initial begin : build_quarter_wave
    logic [63:0] angle;
    for (int m = 0; m <= 512; m++) begin
      angle          = (PI_HALF_Q62 >> 10) * 64'(m);
      sin_quarter[m] = q62_to_q15_mag(taylor_q62(angle, 1'b1));
      cos_quarter[m] = q62_to_q15_mag(taylor_q62(angle, 1'b0));
    end
  end

  function automatic void rewind_pulse();
    gen_position = 24'd0;
    gen_phase    = 48'd0;
    gen_freq     = cfg_tone_step + cfg_chirp_coef;
  endfunction

  function automatic void power_on_generator();
    cfg_tone_step    = 48'd0;
    cfg_chirp_coef   = 48'd0;
    cfg_sample_count = 24'd1;
    rewind_pulse();
  endfunction

  function automatic sample_t next_sample(input logic restart);
    sample_t     s;
    logic [11:0] k;
    logic [9:0]  r;
    int          sin_m;
    int          cos_m;
    logic [23:0] final_pos;
    if (restart) rewind_pulse();
    final_pos = (cfg_sample_count == 24'd0) ? 24'd0 : cfg_sample_count - 24'd1;
    k = gen_phase[47:36];
    r = k[9:0];
    if (r <= 10'd512) begin
      sin_m = sin_quarter[r];
      cos_m = cos_quarter[r];
    end else begin
      sin_m = cos_quarter[1024 - int'(r)];
      cos_m = sin_quarter[1024 - int'(r)];
    end
    case (k[11:10])
      2'd0: begin
        s.re_part = signed_q15(cos_m, 1'b0);
        s.im_part = signed_q15(sin_m, 1'b0);
      end
      2'd1: begin
        s.re_part = signed_q15(sin_m, 1'b1);
        s.im_part = signed_q15(cos_m, 1'b0);
      end
      2'd2: begin
        s.re_part = signed_q15(cos_m, 1'b1);
        s.im_part = signed_q15(sin_m, 1'b1);
      end
      default: begin
        s.re_part = signed_q15(sin_m, 1'b0);
        s.im_part = signed_q15(cos_m, 1'b1);
      end
    endcase
    s.sample_index = gen_position;
    s.last_flag    = (gen_position == final_pos) || (gen_position == COUNT_MAX);
    if (s.last_flag) begin
      rewind_pulse();
    end else begin
      gen_phase    = gen_phase + gen_freq;
      gen_freq     = gen_freq + {cfg_chirp_coef[46:0], 1'b0};
      gen_position = gen_position + 24'd1;
    end
    return s;
  endfunction

  task automatic check_sample();
    sample_t got;
    sample_t want;
    got.re_part      = m_axis_tdata[15:0];
    got.im_part      = m_axis_tdata[31:16];
    got.sample_index = m_axis_tdata[55:32];
    got.last_flag    = m_axis_tlast;
    if (expected_samples.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("unexpected word: re %0d im %0d index %0d last %0b",
                 got.re_part, got.im_part, got.sample_index, got.last_flag);
    end else begin
      want = expected_samples.pop_front();
      if (got.re_part !== want.re_part || got.im_part !== want.im_part ||
          got.sample_index !== want.sample_index || got.last_flag !== want.last_flag) begin
        error_count++;
        if (error_count <= 10)
          $display("sample error: exp re %0d im %0d index %0d last %0b, got re %0d im %0d index %0d last %0b",
                   want.re_part, want.im_part, want.sample_index, want.last_flag,
                   got.re_part, got.im_part, got.sample_index, got.last_flag);
      end
    end
  endtask

  // one process handles config, requests and outputs so their order is fixed
  always @(posedge clk) begin
    if (rst) begin
      power_on_generator();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TONE_STEP:    cfg_tone_step    = cfg_data;
          CFG_CHIRP_COEF:   cfg_chirp_coef   = cfg_data;
          CFG_SAMPLE_COUNT: cfg_sample_count = cfg_data[23:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_samples.push_back(next_sample(s_axis_tdata[0]));
      if (m_axis_tvalid && m_axis_tready)
        check_sample();
    end
  end

  initial begin : receiver
    int mode_left;
    int ready_pct;
    mode_left = 0;
    ready_pct = 100;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      mode_left--;
      m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  task automatic send_request(input logic restart);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [47:0] tone, input logic [47:0] chirp,
                            input logic [23:0] count, input bit poke_spare);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TONE_STEP;
    cfg_data  <= tone;
    @(posedge clk);
    cfg_index <= CFG_CHIRP_COEF;
    cfg_data  <= chirp;
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_COUNT;
    cfg_data  <= {24'd0, count};
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE_INDEX;
      cfg_data  <= random_word48();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] random_word48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic logic [47:0] random_tone();
    case ($urandom_range(0, 4))
      0: return 48'd0;
      1: return PHASE_ALL_ONES;
      default: return random_word48();
    endcase
  endfunction

  function automatic logic [47:0] random_chirp();
    logic [31:0] low;
    logic        sign;
    low  = $urandom();
    sign = $urandom_range(0, 1);
    case ($urandom_range(0, 5))
      0: return 48'd0;
      1: return CHIRP_MOST_NEG;
      2: return CHIRP_MOST_POS;
      3: return random_word48();
      default: return {{20{sign}}, low[27:0]};
    endcase
  endfunction

  function automatic logic [23:0] random_count();
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return COUNT_MAX;
      2: return 24'($urandom_range(1, 300));
      default: return 24'($urandom_range(1, 40));
    endcase
  endfunction

  // reset registers: every sample is last, phase stays at zero
  task automatic test_power_on();
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  task automatic test_directed();
    set_config(PHASE_ALL_ONES, 48'd0, 24'd5, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    // no restart: the new tone step waits for the pulse end, chirp and count apply at once
    set_config(48'd0, CHIRP_MOST_POS, 24'd3, 1'b0);
    repeat (5) send_request(1'b0);
    // restart mid-pulse
    set_config(CHIRP_MOST_NEG, CHIRP_MOST_NEG, 24'd6, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    // quarter-wave midpoint and the entries just past it
    set_config(48'h200000000000, 48'd0, COUNT_MAX, 1'b0);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    set_config(48'h201000000000, 48'd0, COUNT_MAX, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    // zero count acts as one
    set_config(random_word48(), random_chirp(), 24'd0, 1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
  endtask

  task automatic test_backpressure();
    set_config(random_word48(), random_chirp(), 24'd17, 1'b0);
    gap_max    = 0;
    burst_left = 0;
    hold_off_cycles = 100;
    repeat (40) send_request($urandom_range(0, 15) == 0);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 10; phase++) begin
      set_config(random_tone(), random_chirp(), random_count(), 1'b0);
      gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      burst_left = 0;
      repeat (80) send_request($urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on();
    test_directed();
    test_backpressure();
    test_random();
    settle();
    error_count += expected_samples.size();
    if (error_count == 0) begin
      $display("complex_chirp_generator_core: match");
    end else begin
      $display("complex_chirp_generator_core: mismatch");
    end
    $finish;
  end

endmodule
